// ----- rtl/tfd_pkg.sv -----
// Shared types and constants for the tracker frame deframer.
// Used by the parser, the output buffer and the top level; no dependencies.
package tfd_pkg;

   // Frame delimiters.
   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [7:0] TAIL_BYTE   = 8'hFE;

   // Widths of the stream payloads, rounded up to whole bytes.
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 40;

   // Position counter width (seven frame positions).
   localparam int POS_WIDTH = 3;

   // Parser position codes that are also watched outside the parser.
   localparam logic [POS_WIDTH-1:0] POS_CODE_HUNT   = 3'd0;
   localparam logic [POS_WIDTH-1:0] POS_CODE_TAIL   = 3'd6;
   localparam logic [POS_WIDTH-1:0] POS_CODE_UNUSED = 3'd7;

   // One response: the parser state after one request byte.
   typedef struct packed {
      logic        target_seen;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic        frame_done;
   } result_type;

   // Parser status seen by the top level.
   typedef struct packed {
      logic [POS_WIDTH-1:0] position;
   } parse_stat_type;

   // Output buffer occupancy.
   typedef struct packed {
      logic out_full;
      logic skid_full;
   } buf_stat_type;

endpackage

// ----- rtl/tracker_frame_deframer_unit.sv -----
// Tracker frame deframer: one request byte in, one response out per byte.
// Each response is registered in the output buffer when its request is accepted.
// Throughput: one request per cycle while the skid entry is empty; the state
// update and checksum fold are combinational logic fed by the parser registers.
// Reset: synchronous; the parser returns to hunting, the flag and coordinates
// clear, and the output buffer empties.
module tracker_frame_deframer_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [7:0] rx_byte
   input  logic [tfd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [0] target_seen, [16:1] pos_x, [32:17] pos_y, [39:33] zero
   output logic [tfd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // frame_done
   output logic rsp_tlast
);
   import tfd_pkg::*;

   logic           req_accept;
   result_type     parse_result;
   result_type     out_result;
   parse_stat_type parse_stat;
   buf_stat_type   buf_stat;

   assign req_accept = req_tvalid && req_tready;

   // Byte parser.
   tfd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .in_byte  (req_tdata[7:0]),
      .result   (parse_result),
      .stat     (parse_stat)
   );

   // Response buffer.
   tfd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (parse_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result),
      .stat      (buf_stat)
   );

   // Pack the response.
   assign rsp_tdata = {7'd0, out_result.pos_y, out_result.pos_x, out_result.target_seen};
   assign rsp_tlast = out_result.frame_done;

   // The skid entry is only used while the result register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      buf_stat.skid_full |-> buf_stat.out_full)
      else $error("skid entry full while result register empty");

   // The parser never reaches the unused position.
   assert property (@(posedge clock) disable iff (reset)
      parse_stat.position != POS_CODE_UNUSED)
      else $error("parser in unused position");

   // A valid tail returns the parser to hunting and marks the frame done.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && parse_stat.position == POS_CODE_TAIL && req_tdata[7:0] == TAIL_BYTE)
      |=> (parse_stat.position == POS_CODE_HUNT && rsp_tvalid))
      else $error("valid tail did not complete a frame");

   // Requests stall only while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no response pending");

endmodule

// ----- rtl/tfd_parser.sv -----
// Frame parser of the tracker frame deframer: position counter, byte stores,
// checksum and held coordinates. Depends on tfd_pkg.
module tfd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_byte,
   output tfd_pkg::result_type   result,
   output tfd_pkg::parse_stat_type stat
);
   import tfd_pkg::*;

   typedef enum logic [POS_WIDTH-1:0] {
      POS_HUNT = POS_CODE_HUNT,
      POS_X_HIGH,
      POS_X_LOW,
      POS_Y_HIGH,
      POS_Y_LOW,
      POS_CHECK,
      POS_TAIL = POS_CODE_TAIL
   } pos_type;

   // Sum of the two coordinates modulo 254, folded so 256 counts as 2.
   // The quotient estimate is at most one low, so one correction step remains.
   function automatic logic [7:0] mod254(input logic [10:0] s);
      logic [17:0] prod;
      logic [2:0]  q;
      logic [10:0] r;
      prod = {7'd0, s} * 18'd129;
      q    = prod[17:15];
      r    = s - ({8'd0, q} * 11'd254);
      if (r >= 11'd254) begin
         r = r - 11'd254;
      end
      return r[7:0];
   endfunction

   pos_type     pos_ff, pos_in;
   logic [7:0]  x_high_ff, x_high_in;
   logic [7:0]  x_low_ff, x_low_in;
   logic [7:0]  y_high_ff, y_high_in;
   // The y low byte is kept for the tail step.
   logic [7:0]  y_low_ff;
   logic [9:0]  x_part_ff, x_part_in;
   logic [7:0]  check_ff, check_in;
   logic        flag_ff, flag_in;
   logic [15:0] held_x_ff, held_x_in;
   logic [15:0] held_y_ff, held_y_in;
   logic        done;
   logic        bad;
   logic [10:0] sum;

   // Next state for one request byte.
   always_comb begin
      pos_in    = pos_ff;
      x_high_in = x_high_ff;
      x_low_in  = x_low_ff;
      y_high_in = y_high_ff;
      x_part_in = x_part_ff;
      check_in  = check_ff;
      flag_in   = flag_ff;
      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      done      = 1'b0;
      bad       = 1'b0;
      sum       = {1'b0, x_part_ff} + {2'd0, y_high_ff, 1'b0} + {3'd0, in_byte};
      case (pos_ff)
         POS_HUNT: begin
            if (in_byte == HEADER_BYTE) pos_in = POS_X_HIGH;
            else bad = 1'b1;
         end
         POS_X_HIGH: begin
            if (in_byte < HEADER_BYTE) begin
               x_high_in = in_byte;
               pos_in    = POS_X_LOW;
            end else begin
               bad = 1'b1;
            end
         end
         POS_X_LOW: begin
            x_low_in  = in_byte;
            x_part_in = {1'b0, x_high_ff, 1'b0} + {2'd0, in_byte};
            flag_in   = (in_byte != 8'd0);
            pos_in    = POS_Y_HIGH;
         end
         POS_Y_HIGH: begin
            if (in_byte < HEADER_BYTE) begin
               y_high_in = in_byte;
               pos_in    = POS_Y_LOW;
            end else begin
               bad = 1'b1;
            end
         end
         POS_Y_LOW: begin
            held_y_in = held_y_ff;
            check_in  = mod254(sum);
            pos_in    = POS_CHECK;
         end
         POS_CHECK: begin
            if (in_byte == check_ff) pos_in = POS_TAIL;
            else bad = 1'b1;
         end
         POS_TAIL: begin
            if (in_byte == TAIL_BYTE) begin
               pos_in    = POS_HUNT;
               held_x_in = {x_high_ff, x_low_ff};
               held_y_in = {y_high_ff, y_low_ff};
               done      = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase
      if (bad) begin
         pos_in  = POS_HUNT;
         flag_in = 1'b0;
      end
   end

   // State registers, updated on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HUNT;
         flag_ff   <= 1'b0;
         held_x_ff <= 16'd0;
         held_y_ff <= 16'd0;
      end else if (in_valid) begin
         pos_ff    <= pos_in;
         flag_ff   <= flag_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
      end
   end

   // Frame byte stores; each is written before it is read within a frame.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         x_high_ff <= x_high_in;
         x_low_ff  <= x_low_in;
         y_high_ff <= y_high_in;
         x_part_ff <= x_part_in;
         check_ff  <= check_in;
         if (pos_ff == POS_Y_LOW) y_low_ff <= in_byte;
      end
   end

   assign result.target_seen = flag_in;
   assign result.pos_x       = held_x_in;
   assign result.pos_y       = held_y_in;
   assign result.frame_done  = done;
   assign stat.position      = pos_ff;

endmodule

// ----- rtl/tfd_outbuf.sv -----
// Two-entry output buffer (result register plus skid register) for responses.
// Depends on tfd_pkg.
module tfd_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tfd_pkg::result_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tfd_pkg::result_type  out_data,
   output tfd_pkg::buf_stat_type stat
);
   import tfd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       accept;
   logic       main_free;

   assign in_ready  = !skid_valid_ff;
   assign accept    = in_valid && !skid_valid_ff;
   assign main_free = !main_valid_ff || out_ready;

   // The result register refills from the skid entry first, then from input.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         main_valid_in = skid_valid_ff || accept;
         main_in       = skid_valid_ff ? skid_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   // Occupancy flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid      = main_valid_ff;
   assign out_data       = main_ff;
   assign stat.out_full  = main_valid_ff;
   assign stat.skid_full = skid_valid_ff;

endmodule
